// File: sv/mrw_pkg.sv
// Package with shared types and constants for the Miller-Rabin witness round.
`timescale 1ns / 1ps
`default_nettype none
package mrw_pkg;
    localparam int WORD_BITS = 64;
    localparam int SHIFT_BITS = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;

    // Datapath operation codes issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_SHIFT = 3'd2,
        OP_MUL_R = 3'd3,
        OP_MUL_B = 3'd4,
        OP_MUL_X = 3'd5
    } op_t;

    typedef struct packed {
        op_t  op;
        logic start;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic d_odd;
        logic d_zero;
        logic s_zero;
        logic small_done;
        logic small_res;
        logic x_one;
        logic x_triv;
    } stat_t;
endpackage
`default_nettype wire

// File: sv/mrw_datapath.sv
// Datapath: operand registers and a bit-serial modular multiplier.
`timescale 1ns / 1ps
`default_nettype none
module mrw_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire mrw_pkg::word_t cand,
    input  wire mrw_pkg::word_t base,
    input  wire mrw_pkg::cmd_t  cmd,
    output mrw_pkg::stat_t      stat
);
    import mrw_pkg::*;

    localparam logic [SHIFT_BITS:0] CNT_ONE = (SHIFT_BITS+1)'(1);

    word_t n_reg, b_reg, d_reg, r_reg, x_reg;
    word_t acc_reg, mx_reg, my_reg;
    logic [SHIFT_BITS:0] s_reg, cnt_reg;
    logic busy_reg;
    op_t dst_reg;
    logic red_reg;

    // Modular add helpers, computed one bit higher to avoid overflow.
    logic [WORD_BITS:0] dbl, dbl_r, ad, ad_r;
    word_t acc2, acc3;
    always_comb begin
        dbl = {acc_reg, 1'b0};
        dbl_r = dbl - {1'b0, n_reg};
        acc2 = dbl_r[WORD_BITS] ? acc_reg << 1 : dbl_r[WORD_BITS-1:0];
        ad = {1'b0, acc2} + {1'b0, mx_reg};
        ad_r = ad - {1'b0, n_reg};
        acc3 = my_reg[WORD_BITS-1] ? (ad_r[WORD_BITS] ? ad[WORD_BITS-1:0] :
                                      ad_r[WORD_BITS-1:0]) : acc2;
    end

    // Base reduction: shift one base bit into the remainder per cycle.
    logic [WORD_BITS+1:0] rb, rb_r;
    word_t rb_next;
    always_comb begin
        rb = {1'b0, acc_reg, b_reg[WORD_BITS-1]};
        rb_r = rb - {2'b00, n_reg};
        rb_next = rb_r[WORD_BITS+1] ? rb[WORD_BITS-1:0] : rb_r[WORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.start) begin
            unique case (cmd.op)
                OP_LOAD: begin
                    n_reg <= cand;
                    d_reg <= cand - word_t'(1);
                    s_reg <= '0;
                    r_reg <= word_t'(1);
                    b_reg <= base;
                    acc_reg <= '0;
                    cnt_reg <= (SHIFT_BITS+1)'(WORD_BITS);
                    red_reg <= 1'b1;
                    busy_reg <= 1'b1;
                end
                OP_SHIFT: begin
                    d_reg <= d_reg >> 1;
                    s_reg <= s_reg + CNT_ONE;
                end
                OP_MUL_R, OP_MUL_B, OP_MUL_X: begin
                    mx_reg <= (cmd.op == OP_MUL_R) ? r_reg : (cmd.op == OP_MUL_B) ? b_reg : x_reg;
                    my_reg <= (cmd.op == OP_MUL_R) ? b_reg : (cmd.op == OP_MUL_B) ? b_reg : x_reg;
                    acc_reg <= '0;
                    dst_reg <= cmd.op;
                    cnt_reg <= (SHIFT_BITS+1)'(WORD_BITS);
                    busy_reg <= 1'b1;
                    if (cmd.op == OP_MUL_B) d_reg <= d_reg >> 1;
                    if (cmd.op == OP_MUL_X) s_reg <= s_reg - CNT_ONE;
                end
                default: ;
            endcase
        end else if (busy_reg) begin
            if (red_reg) begin
                // Reduce base modulo n, shifting its bits in MSB first.
                acc_reg <= rb_next;
                cnt_reg <= cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE) begin
                    red_reg <= 1'b0;
                    busy_reg <= 1'b0;
                    b_reg <= rb_next;
                end else begin
                    b_reg <= b_reg << 1;
                end
            end else begin
                acc_reg <= acc3;
                my_reg <= my_reg << 1;
                cnt_reg <= cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE) begin
                    busy_reg <= 1'b0;
                    unique case (dst_reg)
                        OP_MUL_R: r_reg <= acc3;
                        OP_MUL_B: b_reg <= acc3;
                        default:  x_reg <= acc3;
                    endcase
                end
            end
        end else if (cmd.op == OP_NONE && dst_reg == OP_MUL_B && d_reg == '0) begin
            x_reg <= r_reg;
            dst_reg <= OP_NONE;
        end
    end

    always_comb begin
        stat.busy = busy_reg;
        stat.d_odd = d_reg[0];
        stat.d_zero = (d_reg == '0);
        stat.s_zero = (s_reg == '0);
        stat.small_done = (n_reg < word_t'(2)) || !n_reg[0] || n_reg == word_t'(3)
                          || n_reg == word_t'(5);
        stat.small_res = (n_reg == word_t'(2)) || n_reg == word_t'(3) || n_reg == word_t'(5);
        stat.x_one = (x_reg == word_t'(1));
        stat.x_triv = (x_reg == word_t'(1)) || (x_reg == n_reg - word_t'(1));
    end
endmodule
`default_nettype wire

// File: sv/mrw_ctrl.sv
// Controller state machine that sequences the witness round.
`timescale 1ns / 1ps
`default_nettype none
module mrw_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_probably_prime,
    input  wire mrw_pkg::stat_t stat,
    output mrw_pkg::cmd_t      cmd
);
    import mrw_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_RED   = 8'b00000010,
        ST_SPLIT = 8'b00000100,
        ST_POW   = 8'b00001000,
        ST_PWAIT = 8'b00010000,
        ST_SQ    = 8'b00100000,
        ST_SWAIT = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic res_reg, res_next, triv_reg, triv_next, rmul_reg, rmul_next;

    always_comb begin
        state_next = state_reg;
        res_next = res_reg;
        triv_next = triv_reg;
        rmul_next = rmul_reg;
        cmd = '{op: OP_NONE, start: 1'b0};
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
        m_probably_prime = res_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd = '{op: OP_LOAD, start: 1'b1};
                state_next = ST_RED;
            end
            ST_RED: if (!stat.busy) begin
                if (stat.small_done) begin
                    res_next = stat.small_res;
                    state_next = ST_OUT;
                end else state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                if (stat.d_odd) state_next = ST_POW;
                else cmd = '{op: OP_SHIFT, start: 1'b1};
                rmul_next = 1'b1;
            end
            ST_POW: begin
                // Multiply result by base when the bit is set, then square base.
                if (stat.d_zero) begin
                    state_next = ST_SQ;
                    res_next = 1'b0;
                end else if (rmul_reg && stat.d_odd) begin
                    cmd = '{op: OP_MUL_R, start: 1'b1};
                    rmul_next = 1'b0;
                    state_next = ST_PWAIT;
                end else begin
                    cmd = '{op: OP_MUL_B, start: 1'b1};
                    rmul_next = 1'b1;
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT: if (!stat.busy) state_next = ST_POW;
            ST_SQ: begin
                if (stat.s_zero) begin
                    res_next = stat.x_one;
                    state_next = ST_OUT;
                end else begin
                    triv_next = stat.x_triv;
                    cmd = '{op: OP_MUL_X, start: 1'b1};
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT: if (!stat.busy) begin
                if (stat.x_one && !triv_reg) begin
                    res_next = 1'b0;
                    state_next = ST_OUT;
                end else state_next = ST_SQ;
            end
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        res_reg <= res_next;
        triv_reg <= triv_next;
        rmul_reg <= rmul_next;
    end
endmodule
`default_nettype wire

// File: sv/miller_rabin_witness_round.sv
// Top level of the Miller-Rabin witness round.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time: a candidate and base go in, one probable-prime flag
// comes out. Small and even candidates settle after the base reduction.
// Otherwise the time is set by the bit-serial modular multiplier, which runs
// one product per bit of d, one per set bit of d and one per squaring step.
module miller_rabin_witness_round (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_candidate,
    input  wire logic [63:0] s_witness_base,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_probably_prime
);
    import mrw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mrw_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .m_probably_prime, .stat, .cmd
    );

    mrw_datapath u_dp (
        .aclk, .aresetn,
        .cand(s_candidate[WORD_BITS-1:0]),
        .base(s_witness_base[WORD_BITS-1:0]),
        .cmd, .stat
    );
endmodule
`default_nettype wire

// File: sv/mrw_checker.sv
// Port-level checker for the witness round and its bind.
`timescale 1ns / 1ps
`default_nettype none
module mrw_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_probably_prime
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("request taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_probably_prime))
        else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second request accepted");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");
endmodule

bind miller_rabin_witness_round mrw_checker u_chk (.*);
`default_nettype wire

// File: dv/miller_rabin_witness_round_test.sv
// Self-checking testbench for the Miller-Rabin witness round block.
`timescale 1ns / 1ps
`default_nettype none
module miller_rabin_witness_round_test;
    import mrw_pkg::*;

    localparam int LIMIT_CYCLES = 60000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_candidate;
    logic [63:0] s_witness_base;
    logic        m_valid;
    logic        m_ready;
    logic        m_probably_prime;

    bit   expected_flags[$];
    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;

    miller_rabin_witness_round u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_candidate     (s_candidate),
        .s_witness_base  (s_witness_base),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_probably_prime(m_probably_prime)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Exact modular product, reduced from the full double-width product.
    function automatic word_t mod_mul(word_t x, word_t y, word_t m);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return word_t'(p % {64'd0, m});
    endfunction

    function automatic word_t mod_pow(word_t b, word_t e, word_t m);
        word_t r;
        r = 1;
        b = b % m;
        while (e != 0) begin
            if (e[0]) r = mod_mul(r, b, m);
            b = mod_mul(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    // Predicts the outcome of one witness round.
    function automatic bit round_passes(word_t n, word_t base);
        word_t d, x;
        int    s;
        bit    nontriv;
        if (n < 2) return 1'b0;
        if (n == 2) return 1'b1;
        if (!n[0]) return 1'b0;
        if (n == 3 || n == 5) return 1'b1;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        x = mod_pow(base, d, n);
        for (int i = 0; i < s; i++) begin
            nontriv = (x != 1) && (x != n - 1);
            x = mod_mul(x, x, n);
            if (x == 1 && nontriv) return 1'b0;
        end
        return x == 1;
    endfunction

    // Sends one request, with a random idle gap first.
    task automatic send_request(word_t n, word_t base);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_candidate    <= n;
        s_witness_base <= base;
        expected_flags.insert(expected_flags.size(), round_passes(n, base));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_flags.size() != 0) @(posedge aclk);
    endtask

    // Receiver stall pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_flags.size() == 0) begin
                $display("%0t: unexpected result, actual %0b", $time, m_probably_prime);
                errors++;
            end else begin
                if (expected_flags[0] !== m_probably_prime) begin
                    $display("%0t: probably_prime mismatch, expected %0b actual %0b",
                             $time, expected_flags[0], m_probably_prime);
                    errors++;
                end
                void'(expected_flags.pop_front());
            end
        end
    end

    // Random 64-bit word.
    function automatic word_t rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Random candidate, mostly odd and of a mostly small size.
    function automatic word_t rand_candidate();
        int    bits;
        word_t n;
        bits = ($urandom_range(9) == 0) ? 64 : $urandom_range(3, 20);
        n = rand_word();
        if (bits < 64) n = n & ((64'd1 << bits) - 1);
        n[0] = ($urandom_range(9) != 0);
        if (bits == 64 && $urandom_range(1)) n[63] = 1'b1;
        return n;
    endfunction

    task automatic test_small_and_even();
        send_request(64'd0, 64'd5);
        send_request(64'd1, 64'd0);
        send_request(64'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(64'd3, 64'd7);
        send_request(64'd4, 64'd2);
        send_request(64'd5, 64'd0);
        send_request(64'hFFFF_FFFF_FFFF_FFFE, 64'd3);
    endtask

    task automatic test_bases();
        send_request(64'd7, 64'd0);
        send_request(64'd7, 64'd14);
        send_request(64'd7, 64'd1);
        send_request(64'd7, 64'd6);
        send_request(64'd561, 64'd2);
        send_request(64'd221, 64'd174);
        send_request(64'd221, 64'd137);
        send_request(64'hFFFF_FFFF_FFFF_FFC5, 64'd2);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
        send_request(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(64'h8000_0000_0000_0001, 64'h5555_AAAA_5555_AAAA);
    endtask

    task automatic test_random(int count);
        word_t n, b;
        for (int i = 0; i < count; i++) begin
            n = rand_candidate();
            case ($urandom_range(3))
                0: b = rand_word();
                1: b = (n > 4) ? 64'd2 + ({32'd0, $urandom()} % (n - 3)) : rand_word();
                2: b = n - 1;
                default: b = {32'd0, $urandom_range(255)};
            endcase
            send_request(n, b);
        end
    endtask

    initial begin
        errors         = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_candidate    = '0;
        s_witness_base = '0;
        send_idle_pct  = 34;
        recv_idle_pct  = 66;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_small_and_even();
        test_bases();
        // The sender holds off here until the pipeline is empty.
        wait_drained();
        test_random(330);
        send_idle_pct = 66;
        recv_idle_pct = 34;
        test_random(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(330);
        wait_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_flags.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
